FILE: rtl/core/triangle_cotan_stiffness_emit_top_assert.svh
// Assertion macros for the cotangent stiffness emitter.
`ifndef TRIANGLE_COTAN_STIFFNESS_EMIT_TOP_ASSERT_SVH
`define TRIANGLE_COTAN_STIFFNESS_EMIT_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tcse_pkg.sv
// Shared widths, constants and the saturation function of the stiffness emitter.
package tcse_pkg;
  localparam int INDEX_BITS_DEF = 20;
  localparam int COORD_W = 32;
  localparam int E_W = 33;
  localparam int SQ_W = 64;
  localparam int L_W = 66;
  localparam int CP_W = 66;
  localparam int CR_W = 67;
  localparam int NA_W = 66;
  localparam int HALF_W = 33;
  localparam int NSQ_W = 132;
  localparam int ROOT_W = 66;
  localparam int REM_W = 69;
  localparam int NUM_W = 68;
  localparam int MAG_W = 67;
  localparam int X_W = 93;
  localparam int D_W = 69;
  localparam int Q_W = 48;
  localparam int M_W = 49;
  localparam int DREM_W = 70;
  localparam int VAL_W = 48;
  localparam int ROUND_SHIFT = 25;
  localparam int DIV_LAT = Q_W + 1;
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] LAST_SLOT = 4'd11;

  // Saturate a sign and magnitude pair into a 48-bit two's complement word.
  function automatic logic [VAL_W-1:0] sat48(input logic neg, input logic [M_W-1:0] mag);
    logic [M_W-1:0] lim;
    logic [M_W-1:0] half;
    half = M_W'(1) << (VAL_W - 1);
    if (neg) begin
      lim = (mag > half) ? half : mag;
      return VAL_W'(-lim);
    end
    lim = (mag > half - M_W'(1)) ? (half - M_W'(1)) : mag;
    return lim[VAL_W-1:0];
  endfunction
endpackage

FILE: rtl/core/tcse_sqrt.sv
// Pipelined integer square root, one root bit resolved per stage.
module tcse_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [tcse_pkg::NSQ_W-1:0]   radicand,
  output logic [tcse_pkg::ROOT_W-1:0]  root
);
  localparam int STAGES = tcse_pkg::ROOT_W;

  logic [tcse_pkg::NSQ_W-1:0]  rad_q  [STAGES-1];
  logic [tcse_pkg::REM_W-1:0]  rem_q  [STAGES];
  logic [tcse_pkg::ROOT_W-1:0] root_q [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    localparam int BIT = STAGES - 1 - g;
    logic [tcse_pkg::NSQ_W-1:0]  rad_in;
    logic [tcse_pkg::REM_W-1:0]  rem_in;
    logic [tcse_pkg::ROOT_W-1:0] root_in;
    logic [tcse_pkg::REM_W+1:0]  trial;
    logic [tcse_pkg::REM_W+1:0]  sub;

    if (g == 0) begin : g_first
      assign rad_in  = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign rad_in  = rad_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign trial = {rem_in, rad_in[2*BIT+1 -: 2]};
    assign sub   = (tcse_pkg::REM_W+2)'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= sub) begin
          rem_q[g]  <= tcse_pkg::REM_W'(trial - sub);
          root_q[g] <= {root_in[tcse_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[g]  <= tcse_pkg::REM_W'(trial);
          root_q[g] <= {root_in[tcse_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end

    if (g < STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rad_q[g] <= rad_in;
        end
      end
    end
  end

  assign root = root_q[STAGES-1];
endmodule

FILE: rtl/core/tcse_div.sv
// Pipelined restoring divider with an overflow check, one quotient bit per stage.
module tcse_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tcse_pkg::X_W-1:0]  dividend,
  input  logic [tcse_pkg::D_W-1:0]  divisor,
  output logic [tcse_pkg::M_W-1:0]  quotient
);
  localparam int QB = tcse_pkg::Q_W;
  localparam int WIDE_W = tcse_pkg::D_W + QB;

  logic                          ovf_q  [QB+1];
  logic [QB-1:0]                 quo_q  [QB+1];
  logic [tcse_pkg::DREM_W-1:0]   rem_q  [QB];
  logic [QB-1:0]                 xlo_q  [QB];
  logic [tcse_pkg::D_W-1:0]      dvs_q  [QB];

  // Setup: flag a quotient of 2^48 or more and load the top dividend bits.
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_q[0] <= (WIDE_W'(dividend) >= {divisor, {QB{1'b0}}});
      quo_q[0] <= '0;
      rem_q[0] <= tcse_pkg::DREM_W'(dividend[tcse_pkg::X_W-1:QB]);
      xlo_q[0] <= dividend[QB-1:0];
      dvs_q[0] <= divisor;
    end
  end

  for (genvar g = 1; g <= QB; g++) begin : g_stage
    localparam int BIT = QB - g;
    logic [tcse_pkg::DREM_W:0] trial;
    logic [tcse_pkg::DREM_W:0] dext;
    logic                      fits;

    assign trial = {rem_q[g-1], xlo_q[g-1][BIT]};
    assign dext  = (tcse_pkg::DREM_W+1)'(dvs_q[g-1]);
    assign fits  = (trial >= dext);

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_q[g] <= ovf_q[g-1];
        quo_q[g] <= quo_q[g-1] | (QB'(fits) << BIT);
      end
    end

    if (g < QB) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[g] <= fits ? tcse_pkg::DREM_W'(trial - dext) : tcse_pkg::DREM_W'(trial);
          xlo_q[g] <= xlo_q[g-1];
          dvs_q[g] <= dvs_q[g-1];
        end
      end
    end
  end

  assign quotient = ovf_q[QB] ? (tcse_pkg::M_W'(1) << QB) : tcse_pkg::M_W'(quo_q[QB]);
endmodule

FILE: rtl/core/triangle_cotan_stiffness_emit_top.sv
// Top level of the cotangent Laplacian element stiffness emitter.
//
//   channel | handshake          | word
//   --------+--------------------+---------------------------------------------
//   in      | in_valid/in_ready  | index_a..index_c, ax..cz (one triangle)
//   out     | out_valid/out_ready| row_index, col_index, entry_value,
//           |                    | degenerate, last (twelve per triangle)
//
// A triangle passes 7 product stages, 66 square root stages, one setup stage,
// 49 divider stages, one saturation stage and the output register before its
// first word is presented.
// The single output port sends one word per cycle while out_ready is high; under
// steady load a new triangle is taken as the last word of the previous one leaves.
// Reset clears the valid bits of all stages and the output counter.
// A stalled output freezes the whole pipeline once a result waits in the final stage; nothing is dropped or repeated.
`include "triangle_cotan_stiffness_emit_top_assert.svh"

module triangle_cotan_stiffness_emit_top #(
  parameter int INDEX_BITS = tcse_pkg::INDEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [INDEX_BITS-1:0]  index_a,
  input  logic [INDEX_BITS-1:0]  index_b,
  input  logic [INDEX_BITS-1:0]  index_c,
  input  logic signed [31:0]     ax,
  input  logic signed [31:0]     ay,
  input  logic signed [31:0]     az,
  input  logic signed [31:0]     bx,
  input  logic signed [31:0]     by,
  input  logic signed [31:0]     bz,
  input  logic signed [31:0]     cx,
  input  logic signed [31:0]     cy,
  input  logic signed [31:0]     cz,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [INDEX_BITS-1:0]  row_index,
  output logic [INDEX_BITS-1:0]  col_index,
  output logic signed [47:0]     entry_value,
  output logic                   degenerate,
  output logic                   last
);
  localparam int SQRT_LAT = tcse_pkg::ROOT_W;

  typedef logic [2:0][INDEX_BITS-1:0] idx3_t;

  typedef struct packed {
    logic                                  valid;
    idx3_t                                 idx;
    logic                                  degen;
    logic [2:0]                            ng;
    logic [2:0][tcse_pkg::MAG_W-1:0]       mag;
  } sq_side_t;

  typedef struct packed {
    logic        valid;
    idx3_t       idx;
    logic        degen;
    logic [2:0]  ng;
  } dv_side_t;

  logic en;
  logic take;

  // Vertex coordinates as an array.
  logic signed [tcse_pkg::COORD_W-1:0] p [3][3];
  always_comb begin
    p[0][0] = ax; p[0][1] = ay; p[0][2] = az;
    p[1][0] = bx; p[1][1] = by; p[1][2] = bz;
    p[2][0] = cx; p[2][1] = cy; p[2][2] = cz;
  end

  // Stage valid bits of the front end.
  logic v1, v2, v3, v4, v5, v6, v7;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  // Stage 1: edge vectors opposite each vertex.
  idx3_t s1_idx;
  logic signed [tcse_pkg::E_W-1:0] s1_e [3][3];
  always_ff @(posedge clk) begin
    if (en) begin
      s1_idx <= {index_c, index_b, index_a};
      for (int k = 0; k < 3; k++) begin
        s1_e[0][k] <= tcse_pkg::E_W'(p[1][k]) - tcse_pkg::E_W'(p[2][k]);
        s1_e[1][k] <= tcse_pkg::E_W'(p[2][k]) - tcse_pkg::E_W'(p[0][k]);
        s1_e[2][k] <= tcse_pkg::E_W'(p[0][k]) - tcse_pkg::E_W'(p[1][k]);
      end
    end
  end

  // Stage 2: squared components and cross-product terms.
  logic signed [tcse_pkg::CP_W-1:0] sqf [3][3];
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int k = 0; k < 3; k++) begin
        sqf[v][k] = s1_e[v][k] * s1_e[v][k];
      end
    end
  end

  idx3_t s2_idx;
  logic [tcse_pkg::SQ_W-1:0] s2_sq [3][3];
  logic signed [tcse_pkg::CP_W-1:0] s2_pr [6];
  always_ff @(posedge clk) begin
    if (en) begin
      s2_idx <= s1_idx;
      for (int v = 0; v < 3; v++) begin
        for (int k = 0; k < 3; k++) begin
          s2_sq[v][k] <= sqf[v][k][tcse_pkg::SQ_W-1:0];
        end
      end
      s2_pr[0] <= s1_e[0][1] * s1_e[1][2];
      s2_pr[1] <= s1_e[0][2] * s1_e[1][1];
      s2_pr[2] <= s1_e[0][2] * s1_e[1][0];
      s2_pr[3] <= s1_e[0][0] * s1_e[1][2];
      s2_pr[4] <= s1_e[0][0] * s1_e[1][1];
      s2_pr[5] <= s1_e[0][1] * s1_e[1][0];
    end
  end

  // Stage 3: squared edge lengths and the cross product.
  idx3_t s3_idx;
  logic [tcse_pkg::L_W-1:0] s3_len [3];
  logic signed [tcse_pkg::CR_W-1:0] s3_n [3];
  always_ff @(posedge clk) begin
    if (en) begin
      s3_idx <= s2_idx;
      for (int v = 0; v < 3; v++) begin
        s3_len[v] <= tcse_pkg::L_W'(s2_sq[v][0]) + tcse_pkg::L_W'(s2_sq[v][1])
                   + tcse_pkg::L_W'(s2_sq[v][2]);
      end
      for (int k = 0; k < 3; k++) begin
        s3_n[k] <= tcse_pkg::CR_W'(s2_pr[2*k]) - tcse_pkg::CR_W'(s2_pr[2*k+1]);
      end
    end
  end

  // Stage 4: cross-product magnitudes, zero test and corner numerators.
  idx3_t s4_idx;
  logic  s4_degen;
  logic [tcse_pkg::NA_W-1:0]  s4_na [3];
  logic [tcse_pkg::NUM_W-1:0] s4_num [3];
  always_ff @(posedge clk) begin
    if (en) begin
      s4_idx   <= s3_idx;
      s4_degen <= (s3_n[0] == '0) && (s3_n[1] == '0) && (s3_n[2] == '0);
      for (int k = 0; k < 3; k++) begin
        s4_na[k] <= s3_n[k][tcse_pkg::CR_W-1] ? tcse_pkg::NA_W'(-s3_n[k])
                                             : tcse_pkg::NA_W'(s3_n[k]);
      end
      for (int j = 0; j < 3; j++) begin
        s4_num[j] <= tcse_pkg::NUM_W'(s3_len[j]) - tcse_pkg::NUM_W'(s3_len[(j+1)%3])
                   - tcse_pkg::NUM_W'(s3_len[(j+2)%3]);
      end
    end
  end

  // Stage 5: half-word products of each cross component; numerator sign split.
  idx3_t s5_idx;
  logic  s5_degen;
  logic [2*tcse_pkg::HALF_W-1:0] s5_hh [3];
  logic [2*tcse_pkg::HALF_W-1:0] s5_hl [3];
  logic [2*tcse_pkg::HALF_W-1:0] s5_ll [3];
  logic [2:0] s5_ng;
  logic [2:0][tcse_pkg::MAG_W-1:0] s5_mag;
  always_ff @(posedge clk) begin
    if (en) begin
      s5_idx   <= s4_idx;
      s5_degen <= s4_degen;
      for (int k = 0; k < 3; k++) begin
        s5_hh[k] <= s4_na[k][tcse_pkg::NA_W-1:tcse_pkg::HALF_W]
                  * s4_na[k][tcse_pkg::NA_W-1:tcse_pkg::HALF_W];
        s5_hl[k] <= s4_na[k][tcse_pkg::NA_W-1:tcse_pkg::HALF_W]
                  * s4_na[k][tcse_pkg::HALF_W-1:0];
        s5_ll[k] <= s4_na[k][tcse_pkg::HALF_W-1:0] * s4_na[k][tcse_pkg::HALF_W-1:0];
      end
      for (int j = 0; j < 3; j++) begin
        s5_ng[j]  <= s4_num[j][tcse_pkg::NUM_W-1];
        s5_mag[j] <= s4_num[j][tcse_pkg::NUM_W-1] ? tcse_pkg::MAG_W'(-s4_num[j])
                                                  : tcse_pkg::MAG_W'(s4_num[j]);
      end
    end
  end

  // Stage 6: assemble each squared cross component.
  idx3_t s6_idx;
  logic  s6_degen;
  logic [2:0] s6_ng;
  logic [2:0][tcse_pkg::MAG_W-1:0] s6_mag;
  logic [tcse_pkg::NSQ_W-1:0] s6_sq [3];
  always_ff @(posedge clk) begin
    if (en) begin
      s6_idx   <= s5_idx;
      s6_degen <= s5_degen;
      s6_ng    <= s5_ng;
      s6_mag   <= s5_mag;
      for (int k = 0; k < 3; k++) begin
        s6_sq[k] <= (tcse_pkg::NSQ_W'(s5_hh[k]) << (2*tcse_pkg::HALF_W))
                  + (tcse_pkg::NSQ_W'(s5_hl[k]) << (tcse_pkg::HALF_W + 1))
                  + tcse_pkg::NSQ_W'(s5_ll[k]);
      end
    end
  end

  // Stage 7: squared cross-product length.
  idx3_t s7_idx;
  logic  s7_degen;
  logic [2:0] s7_ng;
  logic [2:0][tcse_pkg::MAG_W-1:0] s7_mag;
  sq_side_t s7_side;
  logic [tcse_pkg::NSQ_W-1:0] s7_nsq;
  always_ff @(posedge clk) begin
    if (en) begin
      s7_idx   <= s6_idx;
      s7_degen <= s6_degen;
      s7_ng    <= s6_ng;
      s7_mag   <= s6_mag;
      s7_nsq   <= s6_sq[0] + s6_sq[1] + s6_sq[2];
    end
  end
  assign s7_side = {v7, s7_idx, s7_degen, s7_ng, s7_mag};

  // Square root, with the side data delayed to match.
  logic [tcse_pkg::ROOT_W-1:0] root;
  tcse_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (s7_nsq),
    .root     (root)
  );

  sq_side_t sq_side [SQRT_LAT];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQRT_LAT; i++) sq_side[i].valid <= 1'b0;
    end else if (en) begin
      sq_side[0] <= s7_side;
      for (int i = 1; i < SQRT_LAT; i++) sq_side[i] <= sq_side[i-1];
    end
  end

  // Setup stage: rounded dividend and divisor for each corner.
  dv_side_t pr_side;
  logic [tcse_pkg::X_W-1:0] pr_x [3];
  logic [tcse_pkg::D_W-1:0] pr_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      pr_side.valid <= 1'b0;
    end else if (en) begin
      pr_side.valid <= sq_side[SQRT_LAT-1].valid;
      pr_side.idx   <= sq_side[SQRT_LAT-1].idx;
      pr_side.degen <= sq_side[SQRT_LAT-1].degen;
      pr_side.ng    <= sq_side[SQRT_LAT-1].ng;
      for (int j = 0; j < 3; j++) begin
        pr_x[j] <= (tcse_pkg::X_W'(sq_side[SQRT_LAT-1].mag[j]) << tcse_pkg::ROUND_SHIFT)
                 + (tcse_pkg::X_W'(root) << 2);
      end
      pr_d <= tcse_pkg::D_W'(root) << 3;
    end
  end

  // Three corner dividers in parallel.
  logic [tcse_pkg::M_W-1:0] quo [3];
  for (genvar j = 0; j < 3; j++) begin : g_div
    tcse_div u_div (
      .clk      (clk),
      .en       (en),
      .dividend (pr_x[j]),
      .divisor  (pr_d),
      .quotient (quo[j])
    );
  end

  dv_side_t dv_side [tcse_pkg::DIV_LAT];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tcse_pkg::DIV_LAT; i++) dv_side[i].valid <= 1'b0;
    end else if (en) begin
      dv_side[0] <= pr_side;
      for (int i = 1; i < tcse_pkg::DIV_LAT; i++) dv_side[i] <= dv_side[i-1];
    end
  end

  // Final stage: signed, saturated entries; zero for a flat triangle.
  logic fin_valid;
  idx3_t fin_idx;
  logic fin_degen;
  logic [tcse_pkg::VAL_W-1:0] fin_pos [3];
  logic [tcse_pkg::VAL_W-1:0] fin_neg [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= dv_side[tcse_pkg::DIV_LAT-1].valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      fin_idx   <= dv_side[tcse_pkg::DIV_LAT-1].idx;
      fin_degen <= dv_side[tcse_pkg::DIV_LAT-1].degen;
      for (int j = 0; j < 3; j++) begin
        if (dv_side[tcse_pkg::DIV_LAT-1].degen) begin
          fin_pos[j] <= '0;
          fin_neg[j] <= '0;
        end else begin
          fin_pos[j] <= tcse_pkg::sat48(dv_side[tcse_pkg::DIV_LAT-1].ng[j], quo[j]);
          fin_neg[j] <= tcse_pkg::sat48(!dv_side[tcse_pkg::DIV_LAT-1].ng[j], quo[j]);
        end
      end
    end
  end

  // Output holding register and word counter.
  logic busy;
  logic [tcse_pkg::CNT_W-1:0] cnt;
  idx3_t emit_idx;
  logic emit_degen;
  logic [tcse_pkg::VAL_W-1:0] emit_pos [3];
  logic [tcse_pkg::VAL_W-1:0] emit_neg [3];

  assign take     = !busy || (out_ready && (cnt == tcse_pkg::LAST_SLOT));
  assign en       = !fin_valid || take;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take) begin
      busy <= fin_valid;
      cnt  <= '0;
    end else if (out_ready) begin
      cnt <= cnt + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (take && fin_valid) begin
      emit_idx   <= fin_idx;
      emit_degen <= fin_degen;
      emit_pos   <= fin_pos;
      emit_neg   <= fin_neg;
    end
  end

  // Word selection: corner from the upper counter bits, form from the lower.
  logic [1:0] corner;
  logic [INDEX_BITS-1:0] vp;
  logic [INDEX_BITS-1:0] vq;
  logic [tcse_pkg::VAL_W-1:0] cpos;
  logic [tcse_pkg::VAL_W-1:0] cneg;
  always_comb begin
    corner = cnt[3:2];
    unique case (corner)
      2'd0: begin
        vp = emit_idx[1]; vq = emit_idx[2]; cpos = emit_pos[0]; cneg = emit_neg[0];
      end
      2'd1: begin
        vp = emit_idx[2]; vq = emit_idx[0]; cpos = emit_pos[1]; cneg = emit_neg[1];
      end
      2'd2: begin
        vp = emit_idx[0]; vq = emit_idx[1]; cpos = emit_pos[2]; cneg = emit_neg[2];
      end
      default: begin
        vp = '0; vq = '0; cpos = '0; cneg = '0;
      end
    endcase
    unique case (cnt[1:0])
      2'd0: begin row_index = vp; col_index = vq; entry_value = cpos; end
      2'd1: begin row_index = vq; col_index = vp; entry_value = cpos; end
      2'd2: begin row_index = vp; col_index = vp; entry_value = cneg; end
      default: begin row_index = vq; col_index = vq; entry_value = cneg; end
    endcase
  end

  assign out_valid  = busy;
  assign degenerate = emit_degen;
  assign last       = (cnt == tcse_pkg::LAST_SLOT);

  // Checks on the pipeline and the word sequencing.
  `TCSE_ASSERT_NOW(a_degen_zero, out_valid && degenerate, entry_value == '0, "flat triangle gave a nonzero entry")
  `TCSE_ASSERT_NOW(a_diag_words, out_valid && cnt[1], row_index == col_index, "diagonal word has row and column apart")
  `TCSE_ASSERT_NEXT(a_restart, out_valid && out_ready && last, cnt == '0, "word counter did not restart after the last word")
  `TCSE_ASSERT_NOW(a_stall_cause, !in_ready, fin_valid && busy, "input stalled without a waiting result")
endmodule
